// ----- sv/adat_frame_deframer_defines.svh -----
// ----------------------------------------------------------------------------
// ADAT deframer assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAT_FRAME_DEFRAMER_DEFINES_SVH
`define ADAT_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AFD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("adat deframer assertion failed");
// next-cycle implication
`define AFD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adat deframer assertion failed");
`else
`define AFD_ASSERT_IMP(label, ante, cons)
`define AFD_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- sv/afd_pkg.sv -----
// ----------------------------------------------------------------------------
// ADAT deframer package
// Types, constants and helper functions shared by the deframer modules.
// ----------------------------------------------------------------------------
package afd_pkg;

	localparam int WORD_W       = 32;
	localparam int STORE_WORDS  = 8;   // stored words; the ninth is the incoming word
	localparam int FRAME_BITS   = 256;
	localparam int N_CH         = 8;
	localparam int CH_FIRST_BIT = 16;
	localparam int CH_FIELD_W   = 30;
	localparam int SAMPLE_W     = 24;
	localparam int SYNC_W       = 12;

	localparam logic [SYNC_W-1:0] SYNC_PATTERN = 12'h801;
	localparam logic [3:0]        GATHER_FULL  = 4'd8;
	localparam logic [3:0]        NIBBLE_MAX   = 4'd15;

	// configuration register indexes
	localparam logic [1:0] REG_VERIFY_FRAMES = 2'd0;
	localparam logic [1:0] REG_FAIL_LIMIT    = 2'd1;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'b001,
		PH_VERIFY = 3'b010,
		PH_LOCKED = 3'b100
	} phase_t;

	typedef struct packed {
		logic [15:0] errors;
		logic [7:0]  slip;
		logic [7:0]  loss;
		logic [7:0]  lock;
	} stats_t;

	typedef struct packed {
		stats_t                            stats;
		logic [N_CH-1:0][SAMPLE_W-1:0]     samples;
	} frame_t;

	// saturating 8-bit increment
	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	// drop the stuffed 1 ahead of each nibble of a 30-bit channel field
	function automatic logic [SAMPLE_W-1:0] unstuff(input logic [CH_FIELD_W-1:0] v);
		unstuff = {v[28:25], v[23:20], v[18:15], v[13:10], v[8:5], v[3:0]};
	endfunction

endpackage

// ----- sv/afd_sync_search.sv -----
// ----------------------------------------------------------------------------
// ADAT sync search
// Finds the lowest bit offset of the sync pattern across two line words.
// ----------------------------------------------------------------------------
module afd_sync_search (
	input  logic [afd_pkg::WORD_W-1:0] prior_word,
	input  logic [afd_pkg::WORD_W-1:0] word,
	output logic                       found,
	output logic [4:0]                 offset
);

	logic [2*afd_pkg::WORD_W-1:0] pair;

	assign pair = {prior_word, word};

	// independent compares; scanning downward leaves the lowest match
	always_comb begin
		found  = 1'b0;
		offset = '0;
		for (int i = afd_pkg::WORD_W - 1; i >= 0; i--) begin
			if (pair[2*afd_pkg::WORD_W-1-i -: afd_pkg::SYNC_W] == afd_pkg::SYNC_PATTERN) begin
				found  = 1'b1;
				offset = 5'(i);
			end
		end
	end

endmodule

// ----- sv/afd_unstuff.sv -----
// ----------------------------------------------------------------------------
// ADAT frame aligner and unstuffer
// Aligns a nine-word window at the bit offset, checks the header and
// extracts the eight 24-bit channel samples.
// ----------------------------------------------------------------------------
module afd_unstuff (
	input  logic [afd_pkg::STORE_WORDS-1:0][afd_pkg::WORD_W-1:0] store,
	input  logic [afd_pkg::WORD_W-1:0]                            word,
	input  logic [4:0]                                            offset,
	output logic                                                  header_good,
	output logic [afd_pkg::N_CH-1:0][afd_pkg::SAMPLE_W-1:0]       samples
);

	localparam int WIN_W = (afd_pkg::STORE_WORDS + 1) * afd_pkg::WORD_W;

	logic [WIN_W-1:0]                window;
	logic [WIN_W-1:0]                shifted;
	logic [afd_pkg::FRAME_BITS-1:0]  aligned;

	// store[0] is the oldest word and sits in the top bits
	always_comb begin
		for (int w = 0; w < afd_pkg::STORE_WORDS; w++) begin
			window[WIN_W-1-w*afd_pkg::WORD_W -: afd_pkg::WORD_W] = store[w];
		end
		window[afd_pkg::WORD_W-1:0] = word;
	end

	assign shifted     = window << offset;
	assign aligned     = shifted[WIN_W-1 -: afd_pkg::FRAME_BITS];
	assign header_good = (aligned[afd_pkg::FRAME_BITS-1 -: afd_pkg::SYNC_W]
		== afd_pkg::SYNC_PATTERN);

	// channel fields are 30 bits wide, starting 16 bits into the frame
	for (genvar ch = 0; ch < afd_pkg::N_CH; ch++) begin : g_ch
		localparam int POS = afd_pkg::CH_FIRST_BIT + afd_pkg::CH_FIELD_W * ch;
		assign samples[ch] = afd_pkg::unstuff(
			aligned[afd_pkg::FRAME_BITS-1-POS -: afd_pkg::CH_FIELD_W]);
	end

endmodule

// ----- sv/afd_result_buf.sv -----
// ----------------------------------------------------------------------------
// ADAT result buffer
// Holds one decoded frame and drains it as eight output transactions.
// ----------------------------------------------------------------------------
`include "adat_frame_deframer_defines.svh"

module afd_result_buf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  afd_pkg::frame_t               frame,
	output logic                          can_load,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [71:0]                   m_tdata,  // channel, sample, lock, loss, slip, errors
	output logic                          m_tlast
);

	logic [afd_pkg::N_CH-1:0][afd_pkg::SAMPLE_W-1:0] samples_q;
	afd_pkg::stats_t                                 stats_q;
	logic [3:0]                                      cnt_q;
	logic [2:0]                                      ch_q;
	logic                                            pop;

	assign m_tvalid = (cnt_q != 4'd0);
	assign pop      = m_tvalid && m_tready;
	// free now, or the last sample leaves at this edge
	assign can_load = (cnt_q == 4'd0) || ((cnt_q == 4'd1) && m_tready);

	// drain counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ch_q  <= '0;
		end else if (load) begin
			cnt_q <= 4'(afd_pkg::N_CH);
			ch_q  <= '0;
		end else if (pop) begin
			cnt_q <= cnt_q - 4'd1;
			ch_q  <= ch_q + 3'd1;
		end
	end

	// sample shift line and counter snapshot
	always_ff @(posedge clk) begin
		if (load) begin
			samples_q <= frame.samples;
			stats_q   <= frame.stats;
		end else if (pop) begin
			samples_q <= {{afd_pkg::SAMPLE_W{1'b0}}, samples_q[afd_pkg::N_CH-1:1]};
		end
	end

	assign m_tdata = {5'b0, stats_q.errors, stats_q.slip, stats_q.loss, stats_q.lock,
		samples_q[0], ch_q};
	assign m_tlast = (ch_q == 3'd7);

	`AFD_ASSERT_IMP(a_load_free, load, (cnt_q == 4'd0) || ((cnt_q == 4'd1) && pop))
	`AFD_ASSERT_NXT(a_ch_step, pop && (cnt_q > 4'd1) && !load, ch_q == $past(ch_q) + 3'd1)
	`AFD_ASSERT_IMP(a_cnt_ch, m_tvalid, (4'(ch_q) + cnt_q) == 4'd8)

endmodule

// ----- sv/adat_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// ADAT frame deframer
// Hunts for ADAT sync in decoded line words, verifies and tracks frame
// lock, and emits the eight unstuffed channel samples of good locked frames.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tdata[31:0] decoded_word
//   m_*      out  tvalid/tready      tdata channel..errors, tlast last_of_frame
//   cfg_*    in   cfg_valid/ready    cfg_index, cfg_data
//
// One decoded word is taken per cycle; all state updates happen at accept.
// A good locked frame completes on every eighth word and loads an 8-slot
// result register that drains one sample per cycle with m_tready high, from
// the next cycle on. s_tready drops only on a frame-completing word while
// the buffer holds untaken samples. Reset is immediate: no clearing pass.
// ----------------------------------------------------------------------------
module adat_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // decoded_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // channel[2:0], sample[26:3], lock_total[34:27],
	                               // loss_total[42:35], slip_total[50:43],
	                               // header_errors[66:51], zero pad
	output logic        m_tlast,   // last_of_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	afd_pkg::phase_t                                           phase_q, phase_d;
	logic [afd_pkg::WORD_W-1:0]                                prior_q, prior_d;
	logic [afd_pkg::STORE_WORDS-1:0][afd_pkg::WORD_W-1:0]      store_q;
	logic [4:0]                                                offset_q, offset_d;
	logic [3:0]                                                gathered_q, gathered_d;
	logic [3:0]                                                verify_rem_q, verify_rem_d;
	logic [3:0]                                                fail_run_q, fail_run_d;
	afd_pkg::stats_t                                           stats_q, stats_d;
	logic [3:0]                                                verify_frames_q;
	logic [3:0]                                                fail_limit_q;

	logic                                                      accept;
	logic                                                      found;
	logic [4:0]                                                found_offset;
	logic                                                      header_good;
	logic [afd_pkg::N_CH-1:0][afd_pkg::SAMPLE_W-1:0]           samples;
	logic                                                      can_load;
	logic                                                      load;
	afd_pkg::frame_t                                           frame;
	logic                                                      st_we;
	logic [2:0]                                                st_idx;
	logic [afd_pkg::WORD_W-1:0]                                st_wd;
	logic                                                      st_we1;
	logic [3:0]                                                fr_inc;
	logic [3:0]                                                rem_dec;
	logic                                                      completing_locked;

	afd_sync_search u_search (
		.prior_word (prior_q),
		.word       (s_tdata),
		.found      (found),
		.offset     (found_offset)
	);

	afd_unstuff u_unstuff (
		.store       (store_q),
		.word        (s_tdata),
		.offset      (offset_q),
		.header_good (header_good),
		.samples     (samples)
	);

	afd_result_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.frame    (frame),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// backpressure only where a decoded frame could land on a busy buffer
	assign completing_locked = (phase_q == afd_pkg::PH_LOCKED)
		&& (gathered_q == afd_pkg::GATHER_FULL);
	assign s_tready  = !completing_locked || can_load;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign frame.samples = samples;
	assign frame.stats   = stats_q;

	assign fr_inc  = (fail_run_q < afd_pkg::NIBBLE_MAX) ? fail_run_q + 4'd1 : fail_run_q;
	assign rem_dec = (verify_rem_q != 4'd0) ? verify_rem_q - 4'd1 : 4'd0;

	// next-state logic for one accepted word
	always_comb begin
		phase_d      = phase_q;
		prior_d      = prior_q;
		offset_d     = offset_q;
		gathered_d   = gathered_q;
		verify_rem_d = verify_rem_q;
		fail_run_d   = fail_run_q;
		stats_d      = stats_q;
		st_we        = 1'b0;
		st_idx       = gathered_q[2:0];
		st_wd        = s_tdata;
		st_we1       = 1'b0;
		load         = 1'b0;
		if (accept) begin
			case (phase_q)
				afd_pkg::PH_VERIFY, afd_pkg::PH_LOCKED: begin
					if (gathered_q != afd_pkg::GATHER_FULL) begin
						st_we      = 1'b1;
						gathered_d = gathered_q + 4'd1;
					end else if (!header_good) begin
						stats_d.errors = stats_q.errors + 16'd1;
						if ((phase_q == afd_pkg::PH_LOCKED) && (fr_inc < fail_limit_q)) begin
							// skip this frame, keep the lock
							fail_run_d = fr_inc;
							st_we      = 1'b1;
							st_idx     = 3'd0;
							gathered_d = 4'd1;
						end else begin
							if (phase_q == afd_pkg::PH_LOCKED) begin
								stats_d.slip = afd_pkg::sat_inc8(stats_q.slip);
								stats_d.loss = afd_pkg::sat_inc8(stats_q.loss);
								fail_run_d   = 4'd0;
							end
							phase_d    = afd_pkg::PH_HUNT;
							prior_d    = '0;
							gathered_d = 4'd0;
						end
					end else begin
						// good header: carry the last word into the next frame
						st_we      = 1'b1;
						st_idx     = 3'd0;
						gathered_d = 4'd1;
						if (phase_q == afd_pkg::PH_LOCKED) begin
							fail_run_d = 4'd0;
							load       = 1'b1;
						end else begin
							verify_rem_d = rem_dec;
							if (rem_dec == 4'd0) begin
								phase_d      = afd_pkg::PH_LOCKED;
								fail_run_d   = 4'd0;
								stats_d.lock = afd_pkg::sat_inc8(stats_q.lock);
							end
						end
					end
				end
				default: begin
					// hunting, and any unused phase code
					if (found) begin
						st_we        = 1'b1;
						st_idx       = 3'd0;
						st_wd        = prior_q;
						st_we1       = 1'b1;
						gathered_d   = 4'd2;
						offset_d     = found_offset;
						verify_rem_d = verify_frames_q;
						if (verify_frames_q == 4'd0) begin
							phase_d      = afd_pkg::PH_LOCKED;
							fail_run_d   = 4'd0;
							stats_d.lock = afd_pkg::sat_inc8(stats_q.lock);
						end else begin
							phase_d = afd_pkg::PH_VERIFY;
						end
					end else begin
						phase_d = afd_pkg::PH_HUNT;
						prior_d = s_tdata;
					end
				end
			endcase
		end
	end

	// control and counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= afd_pkg::PH_HUNT;
			prior_q      <= '0;
			offset_q     <= '0;
			gathered_q   <= '0;
			verify_rem_q <= '0;
			fail_run_q   <= '0;
			stats_q      <= '0;
		end else begin
			phase_q      <= phase_d;
			prior_q      <= prior_d;
			offset_q     <= offset_d;
			gathered_q   <= gathered_d;
			verify_rem_q <= verify_rem_d;
			fail_run_q   <= fail_run_d;
			stats_q      <= stats_d;
		end
	end

	// frame word store
	always_ff @(posedge clk) begin
		if (st_we) begin
			store_q[st_idx] <= st_wd;
		end
		if (st_we1) begin
			store_q[1] <= s_tdata;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verify_frames_q <= 4'd8;
			fail_limit_q    <= 4'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				afd_pkg::REG_VERIFY_FRAMES: verify_frames_q <= cfg_data;
				afd_pkg::REG_FAIL_LIMIT:    fail_limit_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- tb/adat_frame_deframer_checker.sv -----
// ----------------------------------------------------------------------------
// ADAT deframer result checker
// Watches the word, result and register channels of the deframer, runs a
// frame predictor on every accepted word and compares each accepted result
// transaction field by field with the oldest predicted sample.
// ----------------------------------------------------------------------------
module adat_frame_deframer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	output int          failures,
	output int          outstanding,
	output int          samples_checked
);

	typedef struct {
		logic [2:0]  chan;
		logic [23:0] value;
		logic        last_flag;
		logic [7:0]  locks;
		logic [7:0]  losses;
		logic [7:0]  slips;
		logic [15:0] hdr_errs;
	} sample_rec_t;

	sample_rec_t expected_samples[$];

	// predictor copy of registers and deframer state
	logic [3:0]       verify_frames;
	logic [3:0]       fail_limit;
	afd_pkg::phase_t  phase;
	logic [31:0]      prior_word;
	logic [31:0]      store [0:8];
	logic [4:0]       offset;
	logic [3:0]       gathered;
	logic [3:0]       verify_todo;
	logic [3:0]       fail_run;
	logic [7:0]       lock_cnt;
	logic [7:0]       loss_cnt;
	logic [7:0]       slip_cnt;
	logic [15:0]      err_cnt;

	int fail_count = 0;
	int checked_count = 0;

	assign failures        = fail_count;
	assign samples_checked = checked_count;

	task automatic take_lock();
		phase    = afd_pkg::PH_LOCKED;
		fail_run = '0;
		if (lock_cnt != 8'hFF)
			lock_cnt++;
	endtask

	task automatic restart_hunt();
		phase      = afd_pkg::PH_HUNT;
		prior_word = '0;
		gathered   = '0;
	endtask

	// the ninth word opens the next frame
	task automatic carry_last_word();
		store[0] = store[8];
		gathered = 4'd1;
	endtask

	// advance the predictor by one decoded word, queue the samples it yields
	task automatic deframe_word(input logic [31:0] word);
		logic [63:0]  pair;
		logic [287:0] raw;
		logic [255:0] frame;
		logic [29:0]  field;
		logic         found;
		sample_rec_t  rec;
		int           i;
		int           p;

		// sync search across the previous and current word
		if (phase != afd_pkg::PH_VERIFY && phase != afd_pkg::PH_LOCKED) begin
			pair  = {prior_word, word};
			found = 1'b0;
			for (i = 0; i < 32 && !found; i++) begin
				if (pair[63-i -: 12] == afd_pkg::SYNC_PATTERN) begin
					found       = 1'b1;
					store[0]    = prior_word;
					store[1]    = word;
					gathered    = 4'd2;
					offset      = 5'(i);
					verify_todo = verify_frames;
					if (verify_todo == 0)
						take_lock();
					else
						phase = afd_pkg::PH_VERIFY;
				end
			end
			if (!found) begin
				phase      = afd_pkg::PH_HUNT;
				prior_word = word;
			end
			return;
		end

		// gather nine words before looking at the frame
		if (gathered < 9) begin
			store[gathered] = word;
			gathered++;
		end
		if (gathered < 9)
			return;

		for (i = 0; i < 9; i++)
			raw[287-32*i -: 32] = store[i];
		raw   = raw << offset;
		frame = raw[287:32];

		if (phase == afd_pkg::PH_VERIFY) begin
			if (frame[255:244] != afd_pkg::SYNC_PATTERN) begin
				err_cnt++;
				restart_hunt();
				return;
			end
			if (verify_todo != 0)
				verify_todo--;
			carry_last_word();
			if (verify_todo == 0)
				take_lock();
			return;
		end

		// locked: bad header skips the frame or drops the lock
		if (frame[255:244] != afd_pkg::SYNC_PATTERN) begin
			err_cnt++;
			if (fail_run != 4'hF)
				fail_run++;
			if (fail_run >= fail_limit) begin
				if (slip_cnt != 8'hFF)
					slip_cnt++;
				if (loss_cnt != 8'hFF)
					loss_cnt++;
				fail_run = '0;
				restart_hunt();
			end else begin
				carry_last_word();
			end
			return;
		end

		// good frame: unstuff all eight channel fields
		fail_run = '0;
		for (i = 0; i < afd_pkg::N_CH; i++) begin
			p             = 16 + 30 * i;
			field         = frame[255-p -: 30];
			rec.chan      = 3'(i);
			rec.value     = {field[28:25], field[23:20], field[18:15],
			                 field[13:10], field[8:5], field[3:0]};
			rec.last_flag = (i == afd_pkg::N_CH - 1);
			rec.locks     = lock_cnt;
			rec.losses    = loss_cnt;
			rec.slips     = slip_cnt;
			rec.hdr_errs  = err_cnt;
			expected_samples.push_back(rec);
		end
		carry_last_word();
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		sample_rec_t want;
		if (!arst_n) begin
			verify_frames = 4'd8;
			fail_limit    = 4'd2;
			phase         = afd_pkg::PH_HUNT;
			prior_word    = '0;
			offset        = '0;
			gathered      = '0;
			verify_todo   = '0;
			fail_run      = '0;
			lock_cnt      = '0;
			loss_cnt      = '0;
			slip_cnt      = '0;
			err_cnt       = '0;
			expected_samples.delete();
		end else begin
			// result transaction against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (expected_samples.size() == 0) begin
					$error("result transaction with no sample expected");
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					check_field("channel", want.chan, m_tdata[2:0]);
					check_field("sample", $signed(want.value), $signed(m_tdata[26:3]));
					check_field("last_of_frame", want.last_flag, m_tlast);
					check_field("lock_total", want.locks, m_tdata[34:27]);
					check_field("loss_total", want.losses, m_tdata[42:35]);
					check_field("slip_total", want.slips, m_tdata[50:43]);
					check_field("header_errors", want.hdr_errs, m_tdata[66:51]);
					checked_count++;
				end
			end
			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					afd_pkg::REG_VERIFY_FRAMES: verify_frames = cfg_data;
					afd_pkg::REG_FAIL_LIMIT:    fail_limit = cfg_data;
					default: ;
				endcase
			end
			// word transaction
			if (s_tvalid && s_tready)
				deframe_word(s_tdata);
		end
		outstanding <= expected_samples.size();
	end

endmodule

// ----- tb/adat_frame_deframer_test.sv -----
// ----------------------------------------------------------------------------
// ADAT deframer testbench
// Builds ADAT line streams at random bit offsets, with corrupted headers,
// loose stuffing and noise words, feeds them to the deframer under several
// register settings and random stalls, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module adat_frame_deframer_test;

	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = afd_pkg::REG_VERIFY_FRAMES;
	logic [3:0]  cfg_data = '0;

	int failures;
	int outstanding;
	int samples_checked;

	bit line_bits[$];
	int words_sent = 0;
	int settings_run = 0;
	int cycle_count = 0;
	logic quiet = 1'b0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int gap_left = 0;

	always #5 clk = ~clk;

	adat_frame_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	adat_frame_deframer_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.failures        (failures),
		.outstanding     (outstanding),
		.samples_checked (samples_checked)
	);

	// sample sink: one long hold-off, then random stall bursts; always ready once quiet
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			m_tready  <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (gap_left > 0) begin
			m_tready <= 1'b0;
			gap_left <= gap_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			gap_left <= $urandom_range(0, 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// offer one word, with an occasional idle burst ahead of it
	task automatic send_word(input logic [31:0] w);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	task automatic push_bits(input logic [31:0] v, input int n);
		int i;
		for (i = n - 1; i >= 0; i--)
			line_bits.push_back(v[i]);
	endtask

	// one 256-bit frame: sync, user nibble, eight stuffed 30-bit channels
	task automatic push_frame(input bit bad_header, input bit loose_stuff, input bit extremes);
		logic [11:0] hdr;
		logic [23:0] s;
		int ch;
		int j;
		hdr = afd_pkg::SYNC_PATTERN;
		if (bad_header)
			hdr = hdr ^ (12'h001 << $urandom_range(0, 11));
		push_bits(32'(hdr), 12);
		push_bits($urandom, 4);
		for (ch = 0; ch < afd_pkg::N_CH; ch++) begin
			if (extremes) begin
				case (ch % 4)
					0: s = 24'h7FFFFF;
					1: s = 24'h800000;
					2: s = 24'h000000;
					default: s = 24'hFFFFFF;
				endcase
			end else begin
				s = 24'($urandom);
			end
			for (j = 5; j >= 0; j--) begin
				push_bits(loose_stuff ? $urandom_range(0, 1) : 1, 1);
				push_bits(32'(s[4*j +: 4]), 4);
			end
		end
	endtask

	// send every whole word waiting in the line buffer
	task automatic flush_line();
		logic [31:0] w;
		int i;
		while (line_bits.size() >= 32) begin
			for (i = 0; i < 32; i++)
				w = {w[30:0], line_bits.pop_front()};
			send_word(w);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input logic [3:0] vf, input logic [3:0] fl);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= afd_pkg::REG_VERIFY_FRAMES;
		cfg_data  <= vf;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= afd_pkg::REG_FAIL_LIMIT;
		cfg_data  <= fl;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// noise, then a stream at a random offset; spoil forces one bad header
	task automatic run_segment(input logic [3:0] vf, input logic [3:0] fl, input int spoil);
		int frames;
		int f;
		write_settings(vf, fl);
		repeat ($urandom_range(1, 3)) send_word($urandom);
		push_bits($urandom, $urandom_range(0, 31));
		frames = vf + $urandom_range(2, 3);
		for (f = 0; f < frames; f++) begin
			push_frame(f == spoil || (f > vf + 1 && $urandom_range(0, 3) == 0),
			           $urandom_range(0, 15) == 0, 1'b0);
			flush_line();
		end
		// close the last frame and realign to a word boundary
		push_bits($urandom, (32 - line_bits.size() % 32) % 32);
		push_bits($urandom, 32);
		flush_line();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: instant lock, extreme samples, first bad header drops lock;
		// the sink holds off here so the second good frame stalls the input
		write_settings(4'd0, 4'd0);
		hold_go <= 1'b1;
		send_word(32'h00000000);
		send_word(32'hFFFFFFFF);
		push_frame(1'b0, 1'b0, 1'b1);
		push_frame(1'b0, 1'b0, 1'b0);
		push_frame(1'b1, 1'b0, 1'b0);
		push_bits($urandom, 32);
		flush_line();

		// random streams under several settings
		run_segment(4'd12, 4'd15, -1);
		run_segment(4'd1, 4'd1, -1);
		run_segment(4'd0, 4'd3, -1);
		quiet <= 1'b1;
		run_segment(4'd2, 4'd0, 1);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Fed %0d decoded words through %0d register settings.",
		         words_sent, settings_run);
		$display("Checked %0d channel samples from locked frames.", samples_checked);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/afd_pkg.sv
sv/afd_sync_search.sv
sv/afd_unstuff.sv
sv/afd_result_buf.sv
sv/adat_frame_deframer.sv
tb/adat_frame_deframer_checker.sv
tb/adat_frame_deframer_test.sv
